@@ src/pts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

    // Tone generation constants
    localparam int PHASE_BITS   = 24;
    localparam int SAMPLE_RATE  = 48000;
    localparam int SINE_ENTRIES = 1024;
    localparam int NOTE_CODES   = 128;

    localparam int IDX_BITS     = $clog2(SINE_ENTRIES);
    localparam int SINE_HALF    = SINE_ENTRIES / 2;
    localparam int SINE_QUARTER = SINE_ENTRIES / 4;
    localparam int CLIP_K       = SINE_ENTRIES / 16;   // beyond this the wave is clipped
    localparam int CLIP_W       = $clog2(CLIP_K);

    localparam int MAG_W = 16;
    localparam logic [MAG_W-1:0] WAVE_FULL = 16'h8000;

    // gain = floor(volume * 32767 / 25), divide by 25 via reciprocal
    localparam int VOLP_W     = 32;
    localparam int GAIN_W     = 28;
    localparam int GAIN_SHIFT = 36;
    localparam logic [14:0] GAIN_NUM   = 15'd32767;
    localparam logic [31:0] GAIN_RECIP = 32'd2748779070;

    localparam int TERM_W = MAG_W + GAIN_W;
    localparam int ACC_W  = 16;
    localparam int FRAC   = 31;
    localparam int TOT_W  = 49;

    localparam int ROW_TIMER_W = 23;
    localparam logic [ROW_TIMER_W-1:0] ROW_LIMIT = 23'd4194304;

    localparam longint unsigned INC_DIV    = 64'd800 * 64'(SAMPLE_RATE);
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned Q30_ONE    = 64'd1073741824;

    // Request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Register indexes
    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_SPEED  = 2'd1;
    localparam logic [1:0] CFG_VOLUME = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GAIN,
        ST_READ,
        ST_PHASE,
        ST_MULT,
        ST_ACC,
        ST_FINISH
    } pts_state_t;

    typedef struct packed {
        logic mem_clr;
        logic mem_wr_in;
        logic mem_rd;
        logic gain1;
        logic gain2;
        logic acc_clr;
        logic phase_upd;
        logic mult;
        logic acc_add;
        logic out_load;
    } pts_cmd_t;

    typedef struct packed {
        logic enable;
        logic out_free;
    } pts_stat_t;

    // Semitone base frequency in 0.01 Hz, C4..B4
    function automatic longint unsigned base_centihz(input int semi);
        longint unsigned f;
        case (semi)
            0:       f = 64'd26163;
            1:       f = 64'd27718;
            2:       f = 64'd29366;
            3:       f = 64'd31113;
            4:       f = 64'd32963;
            5:       f = 64'd34923;
            6:       f = 64'd36999;
            7:       f = 64'd39200;
            8:       f = 64'd41530;
            9:       f = 64'd44000;
            10:      f = 64'd46616;
            11:      f = 64'd49388;
            default: f = 64'd0;
        endcase
        return f;
    endfunction

    // Phase increment for a note code; evaluated at elaboration only
    function automatic logic [PHASE_BITS-1:0] inc_calc(input int code);
        longint unsigned f;
        longint unsigned q;
        f = base_centihz(code & 15) << ((code >> 4) & 7);
        q = (f << PHASE_BITS) / INC_DIV;
        return q[PHASE_BITS-1:0];
    endfunction

    // Clipped sine magnitude (Q15) at distance k from a zero crossing
    function automatic logic [MAG_W-1:0] wave_calc(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned x3;
        longint unsigned s;
        longint unsigned v;
        x  = (64'(k) * TWO_PI_Q30) / SINE_ENTRIES;
        x2 = (x * x) >> 30;
        x3 = (x2 * x) >> 30;
        s  = x - x3 / 6;
        v  = s * 16;
        if (v >= Q30_ONE) begin
            return WAVE_FULL;
        end
        v = v >> 15;
        if (v > 64'd32768) begin
            return WAVE_FULL;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ src/pts_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pts_ctrl #(
    parameter int VOICES = 3,
    parameter int ROWS   = 32,
    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1,
    localparam int DEPTH  = VOICES * ROWS,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  pts_pkg::pts_stat_t  stat,
    output pts_pkg::pts_cmd_t   cmd,
    output logic [VW-1:0]       cmd_voice,
    output logic [ADDR_W-1:0]   clr_addr
);
    import pts_pkg::*;

    pts_state_t          state_reg, state_next;
    logic [VW-1:0]       voice_reg, voice_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic                last_voice;
    logic                clr_last;

    assign last_voice = (voice_reg == VW'(VOICES - 1));
    assign clr_last   = (clr_reg == ADDR_W'(DEPTH - 1));
    assign cmd_voice  = voice_reg;
    assign clr_addr   = clr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            voice_reg <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            voice_reg <= voice_next;
            clr_reg   <= clr_next;
        end
    end

    // next state and counters
    always_comb begin
        state_next = state_reg;
        voice_next = voice_reg;
        clr_next   = clr_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && (s_kind == KIND_TICK) && stat.enable) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                voice_next = '0;
                state_next = ST_READ;
            end
            ST_READ:  state_next = ST_PHASE;
            ST_PHASE: state_next = ST_MULT;
            ST_MULT:  state_next = ST_ACC;
            ST_ACC: begin
                if (last_voice) begin
                    state_next = ST_FINISH;
                end else begin
                    voice_next = voice_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.mem_clr = 1'b1;
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.mem_wr_in = s_valid && (s_kind == KIND_WRITE);
                cmd.gain1     = s_valid && (s_kind == KIND_TICK) && stat.enable;
            end
            ST_GAIN: begin
                cmd.gain2   = 1'b1;
                cmd.acc_clr = 1'b1;
            end
            ST_READ:   cmd.mem_rd    = 1'b1;
            ST_PHASE:  cmd.phase_upd = 1'b1;
            ST_MULT:   cmd.mult      = 1'b1;
            ST_ACC:    cmd.acc_add   = 1'b1;
            ST_FINISH: cmd.out_load  = stat.out_free;
            default: ;
        endcase
    end

    a_voice_range: assert property (@(posedge aclk) disable iff (!aresetn)
        voice_reg <= VW'(VOICES - 1))
        else $error("voice counter out of range");

    a_read_then_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_rd |=> cmd.phase_upd && $stable(voice_reg))
        else $error("pattern read not followed by phase update");

    a_gain_starts_voice0: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.gain2 |=> cmd.mem_rd && (voice_reg == '0))
        else $error("tick did not start at first voice");

    a_tick_to_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.gain1 |=> cmd.gain2 && !s_ready)
        else $error("accepted tick did not start gain step");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_clr |-> !s_ready && !cmd.mem_wr_in)
        else $error("request taken during pattern clear");

endmodule

`default_nettype wire

@@ src/pts_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pts_dp #(
    parameter int VOICES = 3,
    parameter int ROWS   = 32,
    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1,
    localparam int RW     = $clog2(ROWS),
    localparam int DEPTH  = VOICES * ROWS,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int IN_W   = ADDR_W + 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pts_pkg::pts_cmd_t   cmd,
    input  logic [VW-1:0]       cmd_voice,
    input  logic [ADDR_W-1:0]   clr_addr,
    input  logic [1:0]          s_voice_sel,
    input  logic [4:0]          s_row_sel,
    input  logic [6:0]          s_note_code,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [16:0]         cfg_data,
    input  logic                m_ready,
    output logic                m_valid,
    output logic signed [15:0]  m_sample,
    output pts_pkg::pts_stat_t  stat
);
    import pts_pkg::*;

    // config
    logic                    enable_reg;
    logic [15:0]             speed_reg;
    logic [16:0]             volume_reg;

    // pattern memory
    logic [6:0]              pat_mem [DEPTH];
    logic [6:0]              pat_rd_reg;
    logic                    wr_ok;
    logic [IN_W-1:0]         in_full;
    logic [IN_W-1:0]         rd_full;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [6:0]              mem_wdata;

    // sequencer state
    logic [PHASE_BITS-1:0]   phase_reg [VOICES];
    logic [RW-1:0]           cur_row_reg;
    logic [ROW_TIMER_W-1:0]  row_timer_reg;
    logic [ROW_TIMER_W-1:0]  row_sum;
    logic                    row_over;

    // tone and mix
    logic [PHASE_BITS-1:0]   inc_rom  [NOTE_CODES];
    logic [MAG_W-1:0]        wave_rom [CLIP_K];
    logic [PHASE_BITS-1:0]   ph_new;
    logic [IDX_BITS-1:0]     idx;
    logic [IDX_BITS-2:0]     jdx;
    logic [IDX_BITS-1:0]     kdist;
    logic [MAG_W-1:0]        mag_next;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [VOLP_W-1:0]       vol_prod_reg;
    logic [VOLP_W+31:0]      gain_prod;
    logic [GAIN_W-1:0]       gain_reg;
    logic [TERM_W-1:0]       term_reg;
    logic signed [TOT_W-1:0] term_s;
    logic signed [TOT_W-1:0] acc_s;
    logic signed [TOT_W-1:0] total;
    logic signed [TOT_W-1:0] total_adj;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_next;
    logic                    m_valid_reg;
    logic [15:0]             m_sample_reg;

    for (genvar g = 0; g < NOTE_CODES; g++) begin : g_inc
        assign inc_rom[g] = inc_calc(g);
    end

    for (genvar g = 0; g < CLIP_K; g++) begin : g_wave
        assign wave_rom[g] = wave_calc(g);
    end

    // pattern write and read addressing
    assign wr_ok   = (32'(s_voice_sel) < VOICES) && (32'(s_row_sel) < ROWS);
    assign in_full = IN_W'(s_voice_sel) * IN_W'(ROWS) + IN_W'(s_row_sel);
    assign rd_full = IN_W'(cmd_voice) * IN_W'(ROWS) + IN_W'(cur_row_reg);
    assign rd_addr = rd_full[ADDR_W-1:0];

    assign mem_we    = cmd.mem_clr || (cmd.mem_wr_in && wr_ok);
    assign mem_waddr = cmd.mem_clr ? clr_addr : in_full[ADDR_W-1:0];
    assign mem_wdata = cmd.mem_clr ? 7'd0 : s_note_code;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pat_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd) begin
            pat_rd_reg <= pat_mem[rd_addr];
        end
    end

    // phase step and clipped sine lookup
    assign ph_new = phase_reg[cmd_voice] + inc_rom[pat_rd_reg];
    assign idx    = ph_new[PHASE_BITS-1 -: IDX_BITS];
    assign jdx    = idx[IDX_BITS-2:0];
    assign kdist  = (IDX_BITS'(jdx) <= IDX_BITS'(SINE_QUARTER)) ? IDX_BITS'(jdx)
                  : IDX_BITS'(SINE_HALF) - IDX_BITS'(jdx);
    assign mag_next = (kdist < IDX_BITS'(CLIP_K)) ? wave_rom[kdist[CLIP_W-1:0]] : WAVE_FULL;

    // gain reciprocal multiply
    assign gain_prod = (VOLP_W + 32)'(vol_prod_reg) * (VOLP_W + 32)'(GAIN_RECIP);

    // mix: add term with 31 fraction bits, truncate toward zero
    assign term_s    = $signed({{(TOT_W - TERM_W){1'b0}}, term_reg});
    assign acc_s     = $signed({{(TOT_W - ACC_W - FRAC){acc_reg[ACC_W-1]}}, acc_reg,
                                {FRAC{1'b0}}});
    assign total     = acc_s + (neg_reg ? -term_s : term_s);
    assign total_adj = total + (total[TOT_W-1] ? TOT_W'((64'd1 << FRAC) - 64'd1)
                                               : TOT_W'(0));
    assign acc_next  = total_adj[FRAC +: ACC_W];

    // row timing
    assign row_sum  = row_timer_reg + ROW_TIMER_W'(speed_reg);
    assign row_over = (row_sum > ROW_LIMIT);

    always_ff @(posedge aclk) begin
        if (cmd.gain1) begin
            vol_prod_reg <= VOLP_W'(volume_reg) * VOLP_W'(GAIN_NUM);
        end
        if (cmd.gain2) begin
            gain_reg <= gain_prod[GAIN_SHIFT +: GAIN_W];
        end
        if (cmd.phase_upd) begin
            mag_reg <= mag_next;
            neg_reg <= idx[IDX_BITS-1];
        end
        if (cmd.mult) begin
            term_reg <= TERM_W'(mag_reg) * TERM_W'(gain_reg);
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_add) begin
            acc_reg <= acc_next;
        end
        if (cmd.out_load) begin
            m_sample_reg <= acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            speed_reg     <= '0;
            volume_reg    <= '0;
            cur_row_reg   <= '0;
            row_timer_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int v = 0; v < VOICES; v++) begin
                phase_reg[v] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_ENABLE: enable_reg <= cfg_data[0];
                    CFG_SPEED:  speed_reg  <= cfg_data[15:0];
                    CFG_VOLUME: volume_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.phase_upd) begin
                phase_reg[cmd_voice] <= ph_new;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
                if (row_over) begin
                    row_timer_reg <= '0;
                    cur_row_reg   <= (cur_row_reg == RW'(ROWS - 1)) ? '0 : cur_row_reg + 1'b1;
                end else begin
                    row_timer_reg <= row_sum;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sample      = $signed(m_sample_reg);
    assign stat.enable   = enable_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

@@ src/pattern_tone_sequencer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Three-voice tone step sequencer with a pattern memory of note codes.
// Input channel (s_*): each request is either a pattern write (s_kind = 0,
//   stored at s_voice_sel / s_row_sel, no result) or a sample
//   tick (s_kind = 1). A tick while enable is clear is taken and dropped.
// Result channel (m_*): one signed 16-bit mixed sample per enabled tick.
// Config channel (cfg_*): index 0 enable, 1 speed, 2 volume; always ready.
// Flow: after a tick is taken, a gain step runs, then each voice costs four
//   steps of the one shared datapath: pattern read, phase add plus sine lookup,
//   gain multiply, accumulate; a final step loads the output register. A new
//   request is taken only once the tick has finished; pattern writes go at
//   one per cycle while no tick is in progress.
// Reset: the pattern memory is swept to zero, one entry a cycle, over all
//   VOICES*ROWS entries; s_ready stays low during the sweep.
//   Phases, row and row timer reset to zero, config registers to zero.
// Stall: the sample sits in an output register, so the next request is
//   taken while it waits; a finished tick holds in its last step until the
//   output register frees up.

module pattern_tone_sequencer_unit #(
    parameter int VOICES = 3,
    parameter int ROWS   = 32
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [1:0]         s_voice_sel,
    input  logic [4:0]         s_row_sel,
    input  logic [6:0]         s_note_code,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data
);
    import pts_pkg::*;

    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ADDR_W = $clog2(VOICES * ROWS);

    pts_cmd_t           cmd;
    pts_stat_t          stat;
    logic [VW-1:0]      cmd_voice;
    logic [ADDR_W-1:0]  clr_addr;

    // registers are to be changed only between ticks; the block does not enforce this, and writes are never held off
    assign cfg_ready = 1'b1;

    pts_ctrl #(
        .VOICES (VOICES),
        .ROWS   (ROWS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .stat      (stat),
        .cmd       (cmd),
        .cmd_voice (cmd_voice),
        .clr_addr  (clr_addr)
    );

    pts_dp #(
        .VOICES (VOICES),
        .ROWS   (ROWS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cmd_voice   (cmd_voice),
        .clr_addr    (clr_addr),
        .s_voice_sel (s_voice_sel),
        .s_row_sel   (s_row_sel),
        .s_note_code (s_note_code),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_sample    (m_sample),
        .stat        (stat)
    );

endmodule

`default_nettype wire
